FILE: rtl/blm_pkg.sv
// ----------------------------------------------------------------------------
// Battery level monitor package
// Shared widths, constants, register indexes, sequencer states and the
// request/response types of the serial divider.
// ----------------------------------------------------------------------------
package blm_pkg;

  // Ring depth of the moving average.
  localparam int WINDOW = 8;

  // Field widths.
  localparam int SAMPLE_W = 12;
  localparam int MV_W     = 16;
  localparam int GAIN_W   = 12;
  localparam int PCT_W    = 7;

  // Widths that follow from the ring depth.
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = MV_W + $clog2(WINDOW);

  // Product widths.
  localparam int RAW_CODE_BITS = 12;
  localparam int RAW_PROD_W    = SAMPLE_W + RAW_CODE_BITS;
  localparam int PCT_PROD_W    = MV_W + PCT_W;
  localparam int SCALE_W       = SAMPLE_W + GAIN_W;

  // Divider operand widths: dividend covers the mean and the percentage.
  localparam int DIV_N_W = (SUM_W > PCT_PROD_W) ? SUM_W : PCT_PROD_W;
  localparam int DIV_D_W = MV_W;
  localparam int DIV_C_W = $clog2(DIV_N_W + 1);

  // Scaling and policy constants.
  localparam int RAW_FULL_MV   = 2500;
  localparam int RAW_FULL_CODE = 4095;
  localparam int WARN_MARGIN   = 200;
  localparam int PCT_FULL      = 100;
  localparam int Q8_SHIFT      = 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FULL_MV       = 3'd0,
    REG_EMPTY_MV      = 3'd1,
    REG_CHARGE_ON_MV  = 3'd2,
    REG_CHARGE_OFF_MV = 3'd3,
    REG_CRITICAL_MV   = 3'd4,
    REG_DIVIDER_GAIN  = 3'd5
  } cfg_reg_t;

  // Register reset values.
  localparam logic [MV_W-1:0]   RST_FULL_MV       = 16'd4200;
  localparam logic [MV_W-1:0]   RST_EMPTY_MV      = 16'd3300;
  localparam logic [MV_W-1:0]   RST_CHARGE_ON_MV  = 16'd4350;
  localparam logic [MV_W-1:0]   RST_CHARGE_OFF_MV = 16'd4100;
  localparam logic [MV_W-1:0]   RST_CRITICAL_MV   = 16'd3400;
  localparam logic [GAIN_W-1:0] RST_DIVIDER_GAIN  = 12'd512;

  // Item sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_SCALE,
    ST_UPDATE,
    ST_MEAN_WAIT,
    ST_FLAGS,
    ST_PCT_WAIT,
    ST_OUT
  } state_t;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/blm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; read data is registered and holds between reads.
// ----------------------------------------------------------------------------
module blm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        en,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                            wdata,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or registered read, at the one address.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/blm_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring division, one quotient bit per cycle; done pulses as the
// last bit is registered, and the quotient holds until the next start.
// ----------------------------------------------------------------------------
module blm_div (
  input  logic             clk,
  input  logic             rst_n,
  input  blm_pkg::div_req_t req,
  output blm_pkg::div_rsp_t rsp
);
  import blm_pkg::*;

  logic               busy_r,  busy_nxt;
  logic               done_r,  done_nxt;
  logic [DIV_C_W-1:0] cnt_r,   cnt_nxt;
  logic [DIV_D_W-1:0] rem_r,   rem_nxt;
  logic [DIV_N_W-1:0] quo_r,   quo_nxt;
  logic [DIV_D_W-1:0] dsr_r,   dsr_nxt;

  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W+1:0] diff;
  logic               ge;

  // Trial subtraction of one step.
  assign shifted = {rem_r, quo_r[DIV_N_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};
  assign ge      = ~diff[DIV_D_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_C_W'(DIV_N_W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
      quo_nxt = {quo_r[DIV_N_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_C_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/battery_level_monitor.sv
// ----------------------------------------------------------------------------
// Battery level monitor
// Moving-average battery voltage with charge percentage, charging
// hysteresis, critical flag and a one-shot low-battery warning.
// ----------------------------------------------------------------------------
// One item at a time: the next item is accepted in the cycle after the result
// is loaded. The time per item is set by the serial divider, which handles one
// quotient bit per cycle (DIV_N_W = 23 steps) and is used once for the mean
// and once more for the percentage when the mean lies strictly between the
// empty and full levels. Raw codes are scaled to millivolts by a reciprocal
// multiplication. The sample ring lives in a single-port RAM that is read
// for the oldest entry on acceptance and written back once the scaled sample
// is ready. A finished result waits in the output register while the next
// item is accepted; if the consumer still holds off when the following result
// is ready, that result waits and no new item is accepted. No clearing pass
// is needed after reset: entries are only used once the ring has been filled.
// ----------------------------------------------------------------------------
module battery_level_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [15:0]                         in_tdata,  // [11:0] sample_value
  input  logic                                in_tuser,  // [0] is_raw_code
  // Result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] mean_mv, [22:16] charge_percent, [23] charging, [24] critical,
  // [25] warn_event
  output logic [31:0]                         out_tdata,
  // Configuration
  input  logic                                cfg_wen,
  input  logic [blm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [blm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import blm_pkg::*;

  // Configuration registers.
  logic [MV_W-1:0]   full_mv_r;
  logic [MV_W-1:0]   empty_mv_r;
  logic [MV_W-1:0]   charge_on_mv_r;
  logic [MV_W-1:0]   charge_off_mv_r;
  logic [MV_W-1:0]   critical_mv_r;
  logic [GAIN_W-1:0] gain_r;

  // Sequencer and persistent state.
  state_t            state_r,  state_nxt;
  logic [IDX_W-1:0]  idx_r,    idx_nxt;
  logic [CNT_W-1:0]  fill_r,   fill_nxt;
  logic [SUM_W-1:0]  sum_r,    sum_nxt;
  logic              charge_r, charge_nxt;
  logic              warned_r, warned_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers of the current item.
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                raw_r,    raw_nxt;
  logic [SAMPLE_W-1:0] pin_r,    pin_nxt;
  logic [MV_W-1:0]     old_r,    old_nxt;
  logic [MV_W-1:0]     batt_r,   batt_nxt;
  logic [MV_W-1:0]     mean_r,   mean_nxt;
  logic [PCT_W-1:0]    pct_r,    pct_nxt;
  logic                crit_r,   crit_nxt;
  logic                warn_r,   warn_nxt;
  logic [31:0]         out_data_r, out_data_nxt;

  // RAM and divider connections.
  logic              ram_en;
  logic              ram_we;
  logic [MV_W-1:0]   ram_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Helper values.
  logic [SCALE_W-1:0]    scale_prod;
  logic [RAW_PROD_W-1:0] raw_prod;
  logic [RAW_PROD_W:0]   raw_quo_sum;
  logic [MV_W:0]         release_mv;
  logic                  ring_full;

  assign scale_prod = SCALE_W'(pin_r) * SCALE_W'(gain_r);
  assign release_mv = {1'b0, critical_mv_r} + (MV_W+1)'(WARN_MARGIN);
  assign ring_full  = (fill_r == CNT_W'(WINDOW));

  // Raw code to millivolts. The full-scale code is 2^12 - 1, so the quotient
  // is (x + (x >> 12) + 1) >> 12, exact while the quotient stays below 2^12.
  assign raw_prod    = RAW_PROD_W'(sample_r) * RAW_PROD_W'(RAW_FULL_MV);
  assign raw_quo_sum = {1'b0, raw_prod} + (RAW_PROD_W+1)'(raw_prod >> RAW_CODE_BITS) +
                       (RAW_PROD_W+1)'(1);

  // Sample ring.
  blm_ram #(
    .WIDTH (MV_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (idx_r),
    .wdata (batt_r),
    .rdata (ram_rdata)
  );

  // Shared serial divider.
  blm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_mv_r       <= RST_FULL_MV;
      empty_mv_r      <= RST_EMPTY_MV;
      charge_on_mv_r  <= RST_CHARGE_ON_MV;
      charge_off_mv_r <= RST_CHARGE_OFF_MV;
      critical_mv_r   <= RST_CRITICAL_MV;
      gain_r          <= RST_DIVIDER_GAIN;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FULL_MV:       full_mv_r       <= cfg_wdata[MV_W-1:0];
        REG_EMPTY_MV:      empty_mv_r      <= cfg_wdata[MV_W-1:0];
        REG_CHARGE_ON_MV:  charge_on_mv_r  <= cfg_wdata[MV_W-1:0];
        REG_CHARGE_OFF_MV: charge_off_mv_r <= cfg_wdata[MV_W-1:0];
        REG_CRITICAL_MV:   critical_mv_r   <= cfg_wdata[MV_W-1:0];
        REG_DIVIDER_GAIN:  gain_r          <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state and datapath control of the item sequencer.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    charge_nxt    = charge_r;
    warned_nxt    = warned_r;
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    raw_nxt       = raw_r;
    pin_nxt       = pin_r;
    old_nxt       = old_r;
    batt_nxt      = batt_r;
    mean_nxt      = mean_r;
    pct_nxt       = pct_r;
    crit_nxt      = crit_r;
    warn_nxt      = warn_r;
    out_data_nxt  = out_data_r;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    div_req       = '{start: 1'b0, dividend: '0, divisor: '0};

    // The consumer takes the waiting result.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Accept an item and read the ring entry it may replace.
      ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata[SAMPLE_W-1:0];
          raw_nxt    = in_tuser;
          ram_en     = 1'b1;
          state_nxt  = ST_RAW;
        end
      end

      // Raw codes are scaled to millivolts at the pin.
      ST_RAW: begin
        old_nxt = ram_rdata;
        if (raw_r) begin
          pin_nxt = raw_quo_sum[RAW_CODE_BITS +: SAMPLE_W];
        end else begin
          pin_nxt = sample_r;
        end
        state_nxt = ST_SCALE;
      end

      // Apply the divider ratio, truncating the Q16.8 product.
      ST_SCALE: begin
        batt_nxt  = scale_prod[Q8_SHIFT +: MV_W];
        state_nxt = ST_UPDATE;
      end

      // Write the ring, update the sum and start the mean division.
      ST_UPDATE: begin
        ram_en  = 1'b1;
        ram_we  = 1'b1;
        sum_nxt = sum_r + SUM_W'(batt_r);
        if (ring_full) begin
          sum_nxt = sum_r - SUM_W'(old_r) + SUM_W'(batt_r);
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
        if (idx_r == IDX_W'(WINDOW - 1)) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'(sum_nxt);
        div_req.divisor  = DIV_D_W'(fill_nxt);
        state_nxt        = ST_MEAN_WAIT;
      end

      ST_MEAN_WAIT: begin
        if (div_rsp.done) begin
          mean_nxt  = div_rsp.quotient[MV_W-1:0];
          state_nxt = ST_FLAGS;
        end
      end

      // Hysteresis, critical and warning latch; percentage bounds.
      ST_FLAGS: begin
        if (!charge_r && (mean_r >= charge_on_mv_r)) begin
          charge_nxt = 1'b1;
        end else if (charge_r && (mean_r < charge_off_mv_r)) begin
          charge_nxt = 1'b0;
        end
        crit_nxt = !charge_nxt && (mean_r < critical_mv_r);
        warn_nxt = 1'b0;
        if (crit_nxt) begin
          if (!warned_r) begin
            warned_nxt = 1'b1;
            warn_nxt   = 1'b1;
          end
        end else if ({1'b0, mean_r} > release_mv) begin
          warned_nxt = 1'b0;
        end
        if (mean_r >= full_mv_r) begin
          pct_nxt   = PCT_W'(PCT_FULL);
          state_nxt = ST_OUT;
        end else if (mean_r <= empty_mv_r) begin
          pct_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_N_W'(PCT_PROD_W'(mean_r - empty_mv_r) *
                                      PCT_PROD_W'(PCT_FULL));
          div_req.divisor  = full_mv_r - empty_mv_r;
          state_nxt        = ST_PCT_WAIT;
        end
      end

      ST_PCT_WAIT: begin
        if (div_rsp.done) begin
          pct_nxt   = div_rsp.quotient[PCT_W-1:0];
          state_nxt = ST_OUT;
        end
      end

      // Hand the result to the output register once it is free.
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, warn_r, crit_r, charge_r, pct_r, mean_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      charge_r    <= 1'b0;
      warned_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      charge_r    <= charge_nxt;
      warned_r    <= warned_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item payload.
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    raw_r      <= raw_nxt;
    pin_r      <= pin_nxt;
    old_r      <= old_nxt;
    batt_r     <= batt_nxt;
    mean_r     <= mean_nxt;
    pct_r      <= pct_nxt;
    crit_r     <= crit_nxt;
    warn_r     <= warn_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
